@@ hw/rtl/ansi_escape_console_parser_defines.svh @@
// Assertion macros used by the console parser top level.
`ifndef ANSI_ESCAPE_CONSOLE_PARSER_DEFINES_SVH
`define ANSI_ESCAPE_CONSOLE_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AECP_CHECK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AECP_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/aecp_pkg.sv @@
// Package: types, constants and helper functions of the console parser.
package aecp_pkg;

    // Default number of parameter slots
    localparam int PARAM_SLOTS_DEF = 8;

    // Register indexes of the configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DBCS_ENABLE   = 1'd1;
    localparam int CFG_DATA_W = 7;

    localparam logic [6:0] INITIAL_COLOR_RST = 7'd7;
    localparam logic       DBCS_ENABLE_RST   = 1'b1;

    // Action codes of a result beat
    localparam logic [2:0] ACT_BYTE      = 3'd0;
    localparam logic [2:0] ACT_PAIR      = 3'd1;
    localparam logic [2:0] ACT_BACKSPACE = 3'd2;
    localparam logic [2:0] ACT_SET_COLOR = 3'd3;
    localparam logic [2:0] ACT_CLEAR     = 3'd4;
    localparam logic [2:0] ACT_CURSOR    = 3'd5;
    localparam logic [2:0] ACT_FLUSH     = 3'd6;

    // Character codes
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_LOWER_M = 8'h6D;
    localparam logic [7:0] CH_UPPER_J = 8'h4A;
    localparam logic [7:0] CH_LOWER_L = 8'h6C;

    // Parameter values and SGR codes
    localparam int PVAL_W = 16;
    localparam logic [PVAL_W-1:0] PARAM_MAX  = 16'hFFFF;
    localparam logic [PVAL_W-1:0] SGR_RESET  = 16'd0;
    localparam logic [PVAL_W-1:0] SGR_BOLD   = 16'd1;
    localparam logic [PVAL_W-1:0] SGR_FG_LO  = 16'd30;
    localparam logic [PVAL_W-1:0] SGR_FG_HI  = 16'd37;
    localparam logic [PVAL_W-1:0] SGR_FG_DEF = 16'd39;
    localparam logic [PVAL_W-1:0] SGR_BG_LO  = 16'd40;
    localparam logic [PVAL_W-1:0] SGR_BG_HI  = 16'd47;
    localparam logic [PVAL_W-1:0] SGR_BG_DEF = 16'd49;

    // Stored slot: empty flag over the value
    localparam int SLOT_DATA_W = PVAL_W + 1;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_SGR,
        TOP_POST
    } top_state_t;

    typedef enum logic [1:0] {
        SGR_IDLE,
        SGR_READ,
        SGR_APPLY
    } sgr_state_t;

    // Request from the parser to the SGR walker
    typedef struct packed {
        logic       start;
        logic [6:0] base_color;
        logic [6:0] dflt_color;
    } sgr_req_t;

    // Status back from the SGR walker
    typedef struct packed {
        logic       done;
        logic [6:0] color;
    } sgr_rsp_t;

    // Shift-JIS lead byte
    function automatic logic is_lead(input logic [7:0] b);
        is_lead = (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
    endfunction

    // ASCII letter
    function automatic logic is_letter(input logic [7:0] b);
        is_letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    // ANSI BGR order to console RGB order
    function automatic logic [2:0] bgr_to_rgb(input logic [2:0] c);
        bgr_to_rgb = {c[0], c[1], c[2]};
    endfunction

endpackage

@@ hw/rtl/aecp_in_if.sv @@
// Interface: input byte channel.
interface aecp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

@@ hw/rtl/aecp_out_if.sv @@
// Interface: console action result channel.
interface aecp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [6:0] color_attr;

    modport source (output valid, output action, output first_byte, output second_byte,
                    output color_attr, input ready);
    modport sink (input valid, input action, input first_byte, input second_byte,
                  input color_attr, output ready);
endinterface

@@ hw/rtl/aecp_sgr_unit.sv @@
// SGR walker: parameter slot memory and a shared compare unit stepped over the slots.
module aecp_sgr_unit #(
    parameter int PARAM_SLOTS = aecp_pkg::PARAM_SLOTS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [$clog2(PARAM_SLOTS)-1:0]        wr_addr,
    input  logic [aecp_pkg::SLOT_DATA_W-1:0]      wr_data,
    input  logic [$clog2(PARAM_SLOTS)-1:0]        limit,
    input  aecp_pkg::sgr_req_t                    req,
    output aecp_pkg::sgr_rsp_t                    rsp
);
    import aecp_pkg::*;

    localparam int SLOT_W = $clog2(PARAM_SLOTS);

    logic [SLOT_DATA_W-1:0] mem [PARAM_SLOTS];
    logic [SLOT_DATA_W-1:0] rd_data_reg;

    sgr_state_t  state_reg, state_next;
    logic [SLOT_W-1:0] walk_idx_reg, walk_idx_next;
    logic [SLOT_W-1:0] limit_reg, limit_next;
    logic [2:0]  fore_reg, fore_next;
    logic [2:0]  back_reg, back_next;
    logic        high_reg, high_next;
    logic [6:0]  dflt_reg, dflt_next;

    logic [2:0]        fore_app, back_app;
    logic              high_app;
    logic [PVAL_W-1:0] pval;
    logic              pempty;
    logic              last;

    // Write one slot, read one slot per step
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SGR_READ)
        begin
            rd_data_reg <= mem[walk_idx_reg];
        end
    end

    assign pval   = rd_data_reg[PVAL_W-1:0];
    assign pempty = rd_data_reg[PVAL_W];
    assign last   = (walk_idx_reg == limit_reg);

    // Shared compare unit: fold one slot into the colour
    always_comb
    begin
        fore_app = fore_reg;
        back_app = back_reg;
        high_app = high_reg;
        if (!pempty)
        begin
            priority if (pval >= SGR_FG_LO && pval <= SGR_FG_HI)
            begin
                fore_app = bgr_to_rgb(3'(pval - SGR_FG_LO));
            end
            else if (pval == SGR_FG_DEF)
            begin
                fore_app = dflt_reg[2:0];
            end
            else if (pval >= SGR_BG_LO && pval <= SGR_BG_HI)
            begin
                back_app = bgr_to_rgb(3'(pval - SGR_BG_LO));
            end
            else if (pval == SGR_BG_DEF)
            begin
                back_app = dflt_reg[6:4];
            end
            else if (pval == SGR_BOLD)
            begin
                high_app = 1'b1;
            end
            else if (pval == SGR_RESET)
            begin
                fore_app = 3'd7;
                back_app = 3'd0;
                high_app = 1'b0;
            end
            else
            begin
                // Unknown code: leave the colour as it is
            end
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SGR_IDLE:
            begin
                if (req.start)
                begin
                    state_next = SGR_READ;
                end
            end
            SGR_READ:
            begin
                state_next = SGR_APPLY;
            end
            SGR_APPLY:
            begin
                state_next = last ? SGR_IDLE : SGR_READ;
            end
            default:
            begin
                state_next = SGR_IDLE;
            end
        endcase
    end

    // Sequencer datapath
    always_comb
    begin
        walk_idx_next = walk_idx_reg;
        limit_next    = limit_reg;
        fore_next     = fore_reg;
        back_next     = back_reg;
        high_next     = high_reg;
        dflt_next     = dflt_reg;
        unique case (state_reg)
            SGR_IDLE:
            begin
                if (req.start)
                begin
                    walk_idx_next = '0;
                    limit_next    = limit;
                    fore_next     = req.base_color[2:0];
                    high_next     = req.base_color[3];
                    back_next     = req.base_color[6:4];
                    dflt_next     = req.dflt_color;
                end
            end
            SGR_APPLY:
            begin
                fore_next = fore_app;
                back_next = back_app;
                high_next = high_app;
                if (!last)
                begin
                    walk_idx_next = walk_idx_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SGR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_idx_reg <= walk_idx_next;
        limit_reg    <= limit_next;
        fore_reg     <= fore_next;
        back_reg     <= back_next;
        high_reg     <= high_next;
        dflt_reg     <= dflt_next;
    end

    assign rsp.done  = (state_reg == SGR_APPLY) && last;
    assign rsp.color = {back_app, high_app, fore_app};

endmodule

@@ hw/rtl/ansi_escape_console_parser.sv @@
// Top level: console byte parser with ANSI escape handling and SGR colour.
//
//   channel   dir   beat payload                                   accepted when
//   in_ch     in    in_byte                                        valid && ready
//   out_ch    out   action, first_byte, second_byte, color_attr    valid && ready
//   cfg       in    cfg_index, cfg_data (no read-back)             cfg_we
//
// Except for an 'm' final, a byte's result, if any, is registered the next cycle.
// The 'm' final walks the parameter slots in aecp_sgr_unit through its slot memory,
// reading each slot in SGR_READ and folding it into the colour in SGR_APPLY.
// Reset (rst_n, asynchronous, active low) clears control state; slots need no clearing.
// in_ch.ready is low in a walk and its colour emit, and while a result cannot drain.
module ansi_escape_console_parser #(
    parameter int PARAM_SLOTS = aecp_pkg::PARAM_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    aecp_in_if.sink                           in_ch,
    aecp_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [aecp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aecp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import aecp_pkg::*;

    `include "ansi_escape_console_parser_defines.svh"

    localparam int SLOT_W = $clog2(PARAM_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(PARAM_SLOTS - 1);

    top_state_t state_reg, state_next;

    logic              esc_mode_reg, esc_mode_next;
    logic              greater_reg, greater_next;
    logic [SLOT_W-1:0] param_index_reg, param_index_next;
    logic [PVAL_W-1:0] acc_reg, acc_next;
    logic              acc_empty_reg, acc_empty_next;
    logic [7:0]        pending_reg, pending_next;
    logic [6:0]        cur_color_reg, cur_color_next;
    logic [6:0]        dflt_color_reg, dflt_color_next;
    logic              dflt_latched_reg, dflt_latched_next;
    logic              dbcs_reg, dbcs_next;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_action_reg, out_action_next;
    logic [7:0]        out_b1_reg, out_b1_next;
    logic [7:0]        out_b2_reg, out_b2_next;
    logic [6:0]        out_color_reg, out_color_next;

    logic              in_fire;
    logic              out_free;
    logic [7:0]        c;
    logic              is_digit;
    logic              is_m;
    logic [PVAL_W-1:0] acc_base;
    logic [19:0]       acc_sum;
    logic [PVAL_W-1:0] acc_sat;

    logic                   slot_wr_en;
    logic [SLOT_DATA_W-1:0] slot_wr_data;
    sgr_req_t               sgr_req;
    sgr_rsp_t               sgr_rsp;

    logic              walk_busy;
    logic              post_go;
    logic              color_beat;

    assign c        = in_ch.in_byte;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign is_digit = (c >= CH_DIGIT0) && (c <= CH_DIGIT9);
    assign is_m     = (c == CH_LOWER_M);

    // Decimal accumulate with saturation
    assign acc_base = acc_empty_reg ? '0 : acc_reg;
    assign acc_sum  = ({4'd0, acc_base} << 3) + ({4'd0, acc_base} << 1)
                    + {16'd0, 4'(c - CH_DIGIT0)};
    assign acc_sat  = (acc_sum[19:16] != 4'd0) ? PARAM_MAX : acc_sum[PVAL_W-1:0];

    // Close the current slot on ';' (room left) or on the 'm' final
    assign slot_wr_en = in_fire && esc_mode_reg
                      && ((c == CH_SEMI && param_index_reg < SLOT_MAX) || is_m);
    assign slot_wr_data = {acc_empty_reg, acc_reg};

    assign sgr_req.start      = in_fire && esc_mode_reg && is_m;
    assign sgr_req.base_color = cur_color_reg;
    assign sgr_req.dflt_color = dflt_latched_reg ? dflt_color_reg : cur_color_reg;

    aecp_sgr_unit #(
        .PARAM_SLOTS (PARAM_SLOTS)
    ) u_sgr (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (slot_wr_en),
        .wr_addr (param_index_reg),
        .wr_data (slot_wr_data),
        .limit   (param_index_reg),
        .req     (sgr_req),
        .rsp     (sgr_rsp)
    );

    // Controller next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TOP_IDLE:
            begin
                if (sgr_req.start)
                begin
                    state_next = TOP_SGR;
                end
            end
            TOP_SGR:
            begin
                if (sgr_rsp.done)
                begin
                    state_next = TOP_POST;
                end
            end
            TOP_POST:
            begin
                if (out_free)
                begin
                    state_next = TOP_IDLE;
                end
            end
            default:
            begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    // Parser datapath and result register
    always_comb
    begin
        esc_mode_next     = esc_mode_reg;
        greater_next      = greater_reg;
        param_index_next  = param_index_reg;
        acc_next          = acc_reg;
        acc_empty_next    = acc_empty_reg;
        pending_next      = pending_reg;
        cur_color_next    = cur_color_reg;
        dflt_color_next   = dflt_color_reg;
        dflt_latched_next = dflt_latched_reg;
        dbcs_next         = dbcs_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        out_action_next   = out_action_reg;
        out_b1_next       = out_b1_reg;
        out_b2_next       = out_b2_reg;
        out_color_next    = out_color_reg;

        // Take register writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INITIAL_COLOR:
                begin
                    cur_color_next = cfg_data;
                end
                CFG_DBCS_ENABLE:
                begin
                    dbcs_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end

        if (in_fire && !esc_mode_reg)
        begin
            // Printing mode
            out_b1_next    = '0;
            out_b2_next    = '0;
            out_color_next = '0;
            priority if (c == CH_ESC)
            begin
                esc_mode_next    = 1'b1;
                greater_next     = 1'b0;
                param_index_next = '0;
                acc_next         = '0;
                acc_empty_next   = 1'b0;
                out_valid_next   = 1'b1;
                out_action_next  = ACT_FLUSH;
            end
            else if (c == CH_BS)
            begin
                out_valid_next  = 1'b1;
                out_action_next = ACT_BACKSPACE;
            end
            else if (pending_reg != 8'd0)
            begin
                pending_next    = '0;
                out_valid_next  = 1'b1;
                out_action_next = ACT_PAIR;
                out_b1_next     = pending_reg;
                out_b2_next     = c;
            end
            else if (dbcs_reg && is_lead(c))
            begin
                pending_next = c;
            end
            else
            begin
                out_valid_next  = 1'b1;
                out_action_next = ACT_BYTE;
                out_b1_next     = c;
            end
        end
        else if (in_fire)
        begin
            // Escape mode
            out_b1_next    = '0;
            out_b2_next    = '0;
            out_color_next = '0;
            priority if (c == CH_BRACKET)
            begin
            end
            else if (c == CH_GREATER)
            begin
                greater_next = 1'b1;
            end
            else if (is_digit)
            begin
                acc_next       = acc_sat;
                acc_empty_next = 1'b0;
            end
            else if (c == CH_SEMI)
            begin
                if (param_index_reg < SLOT_MAX)
                begin
                    param_index_next = param_index_reg + 1'b1;
                    acc_next         = '0;
                    acc_empty_next   = 1'b1;
                end
            end
            else
            begin
                // Any final or stray byte ends the sequence
                esc_mode_next    = 1'b0;
                param_index_next = '0;
                if (is_m)
                begin
                    dflt_color_next   = sgr_req.dflt_color;
                    dflt_latched_next = 1'b1;
                end
                else if (c == CH_UPPER_J)
                begin
                    out_valid_next  = 1'b1;
                    out_action_next = ACT_CLEAR;
                end
                else if (c == CH_LOWER_L && greater_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_action_next = ACT_CURSOR;
                end
            end
        end

        // Take the walked colour
        if (sgr_rsp.done)
        begin
            cur_color_next = sgr_rsp.color;
        end

        // Emit the colour once the output register is free
        if (state_reg == TOP_POST && out_free)
        begin
            out_valid_next  = 1'b1;
            out_action_next = ACT_SET_COLOR;
            out_b1_next     = '0;
            out_b2_next     = '0;
            out_color_next  = cur_color_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= TOP_IDLE;
            esc_mode_reg     <= 1'b0;
            greater_reg      <= 1'b0;
            param_index_reg  <= '0;
            pending_reg      <= '0;
            cur_color_reg    <= INITIAL_COLOR_RST;
            dflt_color_reg   <= '0;
            dflt_latched_reg <= 1'b0;
            dbcs_reg         <= DBCS_ENABLE_RST;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            esc_mode_reg     <= esc_mode_next;
            greater_reg      <= greater_next;
            param_index_reg  <= param_index_next;
            pending_reg      <= pending_next;
            cur_color_reg    <= cur_color_next;
            dflt_color_reg   <= dflt_color_next;
            dflt_latched_reg <= dflt_latched_next;
            dbcs_reg         <= dbcs_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        acc_empty_reg  <= acc_empty_next;
        out_action_reg <= out_action_next;
        out_b1_reg     <= out_b1_next;
        out_b2_reg     <= out_b2_next;
        out_color_reg  <= out_color_next;
    end

    assign in_ch.ready        = (state_reg == TOP_IDLE) && out_free;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.action      = out_action_reg;
    assign out_ch.first_byte  = out_b1_reg;
    assign out_ch.second_byte = out_b2_reg;
    assign out_ch.color_attr  = out_color_reg;

    // Checks
    assign walk_busy  = (state_reg == TOP_SGR);
    assign post_go    = (state_reg == TOP_POST) && out_free;
    assign color_beat = out_valid_reg && (out_action_reg == ACT_SET_COLOR);

    `AECP_CHECK_IMPL(a_done_only_in_walk, sgr_rsp.done, walk_busy, "walk done outside walk")
    `AECP_CHECK_NEXT(a_m_starts_walk, sgr_req.start, walk_busy, "'m' did not start walk")
    `AECP_CHECK_NEXT(a_post_emits_color, post_go, color_beat, "colour beat missing")
    `AECP_CHECK_IMPL(a_index_in_range, 1'b1, param_index_reg <= SLOT_MAX, "slot index bad")

endmodule
